// ===== hw/rtl/utf8_to_pdf_literal_escaper_defines.svh =====
// Assertion macros used by the escaper RTL.
`ifndef UTF8_TO_PDF_LITERAL_ESCAPER_DEFINES_SVH
`define UTF8_TO_PDF_LITERAL_ESCAPER_DEFINES_SVH

// same-cycle implication
`define U8ESC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("u8esc implication check failed");

// next-cycle implication
`define U8ESC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("u8esc next-cycle check failed");

`endif

// ===== hw/rtl/u8esc_pkg.sv =====
// Types and constants for the UTF-8 to PDF literal string escaper.
`default_nettype none
package u8esc_pkg;

	localparam int unsigned CP_W   = 21;
	localparam int unsigned PLAN_N = 8;

	localparam logic [CP_W-1:0] CP_PRINT_LO = 21'h00020;
	localparam logic [CP_W-1:0] CP_PRINT_HI = 21'h0007E;
	localparam logic [CP_W-1:0] CP_LATIN_LO = 21'h000A0;
	localparam logic [CP_W-1:0] CP_LATIN_HI = 21'h000FF;

	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_MASK = 8'hE0;
	localparam logic [7:0] LEAD2_TAG  = 8'hC0;
	localparam logic [7:0] LEAD3_MASK = 8'hF0;
	localparam logic [7:0] LEAD3_TAG  = 8'hE0;
	localparam logic [7:0] LEAD4_MASK = 8'hF8;
	localparam logic [7:0] LEAD4_TAG  = 8'hF0;

	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [4:0] CH_DIGIT_HI = 5'b00110;

	// bytes one input word expands to
	typedef struct packed {
		logic [PLAN_N-1:0][7:0] data;
		logic [3:0]             cnt;
		logic                   eot;
	} plan_t;

endpackage
`default_nettype wire

// ===== hw/rtl/u8esc_decode.sv =====
// UTF-8 decode state and expansion of one input word into escaped bytes.
`default_nettype none
module u8esc_decode (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            take,
	input  wire logic [7:0]      in_byte,
	input  wire logic            end_of_text,
	output u8esc_pkg::plan_t     plan
);

	logic [7:0]                 pending_lead_q;
	logic [u8esc_pkg::CP_W-1:0] partial_code_q;
	logic [1:0]                 bytes_remaining_q;

	logic                       cont, seq_open, broken, complete, fresh_en, fresh_ascii;
	logic                       opens, open_after, end_close;
	logic [1:0]                 open_rem;
	logic [u8esc_pkg::CP_W-1:0] open_bits, acc_code, cp0;
	logic [7:0]                 lead_after;
	logic                       v0, v1;
	logic [1:0]                 nxt_rem;

	logic                       keep0, keep1;
	logic [7:0]                 ch0, ch1;
	logic [2:0]                 len0, len1;
	logic [3:0][7:0]            esc0, esc1;
	logic [3:0]                 pos, rel;

	function automatic logic [8:0] map_cp(input logic [u8esc_pkg::CP_W-1:0] cp);
		logic [8:0] r;
		if (cp < u8esc_pkg::CP_PRINT_LO)
			r = 9'h000;
		else if (cp <= u8esc_pkg::CP_PRINT_HI)
			r = {1'b1, cp[7:0]};
		else if (cp >= u8esc_pkg::CP_LATIN_LO && cp <= u8esc_pkg::CP_LATIN_HI)
			r = {1'b1, cp[7:0]};
		else
			r = {1'b1, u8esc_pkg::CH_QMARK};
		return r;
	endfunction

	function automatic logic [34:0] escape(input logic keep, input logic [7:0] c);
		logic [2:0]      n;
		logic [3:0][7:0] s;
		s = '0;
		n = 3'd0;
		if (keep) begin
			if (c == u8esc_pkg::CH_LPAREN || c == u8esc_pkg::CH_RPAREN ||
			    c == u8esc_pkg::CH_BSLASH) begin
				s[0] = u8esc_pkg::CH_BSLASH;
				s[1] = c;
				n = 3'd2;
			end else if (c[7]) begin
				s[0] = u8esc_pkg::CH_BSLASH;
				s[1] = {u8esc_pkg::CH_DIGIT_HI, 1'b0, c[7:6]};
				s[2] = {u8esc_pkg::CH_DIGIT_HI, c[5:3]};
				s[3] = {u8esc_pkg::CH_DIGIT_HI, c[2:0]};
				n = 3'd4;
			end else begin
				s[0] = c;
				n = 3'd1;
			end
		end
		return {n, s};
	endfunction

	always_comb begin
		cont     = (in_byte & u8esc_pkg::CONT_MASK) == u8esc_pkg::CONT_TAG;
		seq_open = bytes_remaining_q != 2'd0;
		broken   = seq_open && !cont;
		complete = seq_open && cont && bytes_remaining_q == 2'd1;
		fresh_en = !seq_open || broken;
		fresh_ascii = fresh_en && !in_byte[7];
		acc_code = {partial_code_q[u8esc_pkg::CP_W-7:0], in_byte[5:0]};

		opens     = 1'b0;
		open_rem  = 2'd0;
		open_bits = '0;
		if ((in_byte & u8esc_pkg::LEAD2_MASK) == u8esc_pkg::LEAD2_TAG) begin
			opens = fresh_en;
			open_rem = 2'd1;
			open_bits = {16'd0, in_byte[4:0]};
		end else if ((in_byte & u8esc_pkg::LEAD3_MASK) == u8esc_pkg::LEAD3_TAG) begin
			opens = fresh_en;
			open_rem = 2'd2;
			open_bits = {17'd0, in_byte[3:0]};
		end else if ((in_byte & u8esc_pkg::LEAD4_MASK) == u8esc_pkg::LEAD4_TAG) begin
			opens = fresh_en;
			open_rem = 2'd3;
			open_bits = {18'd0, in_byte[2:0]};
		end

		open_after = (seq_open && cont && bytes_remaining_q != 2'd1) || opens;
		lead_after = opens ? in_byte : pending_lead_q;
		end_close  = end_of_text && open_after;

		if (seq_open && cont)
			nxt_rem = bytes_remaining_q - 2'd1;
		else if (opens)
			nxt_rem = open_rem;
		else
			nxt_rem = 2'd0;
		if (end_of_text)
			nxt_rem = 2'd0;

		// at most two code points per word, in emission order
		v0 = complete || broken || fresh_ascii || end_close;
		if (complete)
			cp0 = acc_code;
		else if (broken)
			cp0 = {13'd0, pending_lead_q};
		else if (fresh_ascii)
			cp0 = {13'd0, in_byte};
		else
			cp0 = {13'd0, lead_after};
		v1 = broken && (fresh_ascii || end_close);

		{keep0, ch0} = map_cp(cp0);
		{keep1, ch1} = map_cp({13'd0, in_byte});
		{len0, esc0} = escape(keep0 && v0, ch0);
		{len1, esc1} = escape(keep1 && v1, ch1);

		plan.cnt = {1'b0, len0} + {1'b0, len1};
		plan.eot = end_of_text;
		pos = 4'd0;
		rel = 4'd0;
		for (int i = 0; i < u8esc_pkg::PLAN_N; i++) begin
			pos = 4'(i);
			rel = pos - {1'b0, len0};
			if (pos < {1'b0, len0})
				plan.data[i] = esc0[pos[1:0]];
			else if (rel < {1'b0, len1})
				plan.data[i] = esc1[rel[1:0]];
			else
				plan.data[i] = 8'h00;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_lead_q    <= 8'h00;
			partial_code_q    <= '0;
			bytes_remaining_q <= 2'd0;
		end else if (take) begin
			bytes_remaining_q <= nxt_rem;
			if (seq_open && cont)
				partial_code_q <= acc_code;
			else if (opens)
				partial_code_q <= open_bits;
			if (opens)
				pending_lead_q <= in_byte;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/u8esc_emit.sv =====
// Plan register and output register that send one escaped byte per word.
`default_nettype none
`include "utf8_to_pdf_literal_escaper_defines.svh"
module u8esc_emit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire u8esc_pkg::plan_t  plan,
	output logic                   plan_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             esc_byte,
	output logic                   byte_valid,
	output logic                   last
);

	u8esc_pkg::plan_t plan_s1;
	logic             plan_valid_s1;
	logic [2:0]       idx_q;
	logic             out_valid_q;
	logic [3:0]       len_eff;
	logic [2:0]       last_idx;
	logic             slot_free, fire, done;

	always_comb begin
		len_eff    = (plan_s1.cnt == 4'd0) ? 4'd1 : plan_s1.cnt;
		last_idx   = 3'(len_eff - 4'd1);
		slot_free  = !out_valid_q || out_ready;
		fire       = plan_valid_s1 && slot_free;
		done       = fire && idx_q == last_idx;
		plan_ready = !plan_valid_s1 || done;
		out_valid  = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plan_valid_s1 <= 1'b0;
			idx_q         <= 3'd0;
		end else if (load) begin
			plan_valid_s1 <= 1'b1;
			idx_q         <= 3'd0;
		end else if (done) begin
			plan_valid_s1 <= 1'b0;
			idx_q         <= 3'd0;
		end else if (fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			plan_s1 <= plan;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (fire)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			esc_byte   <= plan_s1.data[idx_q];
			byte_valid <= plan_s1.cnt != 4'd0;
			last       <= plan_s1.eot && idx_q == last_idx;
		end
	end

	`U8ESC_ASSERT_IMP(a_empty_is_last, clk, arst_n, out_valid_q && !byte_valid, last)
	`U8ESC_ASSERT_IMP(a_idx_in_range, clk, arst_n, plan_valid_s1, {1'b0, idx_q} < len_eff)
	`U8ESC_ASSERT_IMP(a_no_overrun, clk, arst_n, plan_valid_s1 && !done, !plan_ready)
	`U8ESC_ASSERT_NXT(a_load_shows, clk, arst_n, load, plan_valid_s1 && idx_q == 3'd0)

endmodule
`default_nettype wire

// ===== hw/rtl/utf8_to_pdf_literal_escaper.sv =====
// Top level of the UTF-8 to PDF literal string escaper.
//
//  channel | handshake           | payload
//  in      | in_valid/in_ready   | in_byte, end_of_text
//  out     | out_valid/out_ready | esc_byte, byte_valid, last
//
// A word is decoded combinationally in the cycle it is accepted; its result
// bytes are loaded into the plan register and then pass through the output
// register. The 0..8 result bytes leave one per cycle while out_ready holds,
// and the input waits while they drain. An empty end marker yields one word
// with byte_valid low; a word with no result loads nothing into the plan.
// in_ready drops while a loaded plan still drains, unless its last byte leaves in this cycle.
// Reset clears the decode state and the plan and output valid flags (not byte_valid).
`default_nettype none
module utf8_to_pdf_literal_escaper (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      esc_byte,
	output logic            byte_valid,
	output logic            last
);

	u8esc_pkg::plan_t plan;
	logic             take, load, plan_ready;

	assign in_ready = plan_ready;
	assign take     = in_valid && plan_ready;
	assign load     = take && (plan.cnt != 4'd0 || plan.eot);

	u8esc_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.plan        (plan)
	);

	u8esc_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.plan       (plan),
		.plan_ready (plan_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.esc_byte   (esc_byte),
		.byte_valid (byte_valid),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== verif/escaper_checker.sv =====
// Checker for the UTF-8 to PDF literal string escaper: predicts and compares every output word.
module escaper_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_ready,
	input  logic [7:0]      in_byte,
	input  logic            end_of_text,
	input  logic            out_valid,
	input  logic            out_ready,
	input  logic [7:0]      esc_byte,
	input  logic            byte_valid,
	input  logic            last,
	output int unsigned     fail_count,
	output int unsigned     pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] DIGIT_ZERO = 8'h30;

	typedef logic [u8esc_pkg::CP_W-1:0] cp_t;

	typedef struct packed {
		logic [7:0] esc_byte;
		logic       byte_valid;
		logic       last;
	} esc_word_t;

	esc_word_t escaped_q[$];
	esc_word_t word_q[$];

	logic [7:0] lead_q    = '0;
	cp_t        code_acc  = '0;
	logic [1:0] remaining = '0;

	function automatic void push_char(logic [7:0] ch);
		word_q.push_back('{ch, 1'b1, 1'b0});
	endfunction

	function automatic void emit_point(cp_t cp);
		logic [7:0] ch;
		if (cp >= u8esc_pkg::CP_PRINT_LO && cp <= u8esc_pkg::CP_PRINT_HI)
			ch = cp[7:0];
		else if (cp >= u8esc_pkg::CP_LATIN_LO && cp <= u8esc_pkg::CP_LATIN_HI)
			ch = cp[7:0];
		else if (cp < u8esc_pkg::CP_PRINT_LO)
			return;
		else
			ch = u8esc_pkg::CH_QMARK;
		if (ch == u8esc_pkg::CH_LPAREN || ch == u8esc_pkg::CH_RPAREN ||
		    ch == u8esc_pkg::CH_BSLASH) begin
			push_char(u8esc_pkg::CH_BSLASH);
			push_char(ch);
		end else if (ch[7]) begin
			push_char(u8esc_pkg::CH_BSLASH);
			push_char(DIGIT_ZERO + {6'b0, ch[7:6]});
			push_char(DIGIT_ZERO + {5'b0, ch[5:3]});
			push_char(DIGIT_ZERO + {5'b0, ch[2:0]});
		end else begin
			push_char(ch);
		end
	endfunction

	function automatic void decode_fresh(logic [7:0] b);
		if (!b[7]) begin
			emit_point(cp_t'(b));
		end else if ((b & u8esc_pkg::LEAD2_MASK) == u8esc_pkg::LEAD2_TAG) begin
			lead_q = b;
			code_acc = cp_t'(b[4:0]);
			remaining = 2'd1;
		end else if ((b & u8esc_pkg::LEAD3_MASK) == u8esc_pkg::LEAD3_TAG) begin
			lead_q = b;
			code_acc = cp_t'(b[3:0]);
			remaining = 2'd2;
		end else if ((b & u8esc_pkg::LEAD4_MASK) == u8esc_pkg::LEAD4_TAG) begin
			lead_q = b;
			code_acc = cp_t'(b[2:0]);
			remaining = 2'd3;
		end
	endfunction

	function automatic void predict_escape(logic [7:0] b, logic eot);
		word_q.delete();
		if (remaining != 0) begin
			if ((b & u8esc_pkg::CONT_MASK) == u8esc_pkg::CONT_TAG) begin
				code_acc = {code_acc[u8esc_pkg::CP_W-7:0], b[5:0]};
				remaining = remaining - 2'd1;
				if (remaining == 0)
					emit_point(code_acc);
			end else begin
				// broken sequence: lead stands alone, byte starts over
				remaining = 2'd0;
				emit_point(cp_t'(lead_q));
				decode_fresh(b);
			end
		end else begin
			decode_fresh(b);
		end
		if (eot) begin
			if (remaining != 0) begin
				remaining = 2'd0;
				emit_point(cp_t'(lead_q));
			end
			if (word_q.size() == 0)
				word_q.push_back('{8'h00, 1'b0, 1'b1});
			else
				word_q[word_q.size()-1].last = 1'b1;
		end
		foreach (word_q[i])
			escaped_q.push_back(word_q[i]);
	endfunction

	always @(posedge clk) begin
		esc_word_t exp_w;
		if (!arst_n) begin
			lead_q = '0;
			code_acc = '0;
			remaining = '0;
			escaped_q.delete();
		end else begin
			if (in_valid && in_ready)
				predict_escape(in_byte, end_of_text);
			if (out_valid && out_ready) begin
				if (escaped_q.size() == 0) begin
					$error("unexpected word: esc_byte %h byte_valid %b last %b",
						esc_byte, byte_valid, last);
					fail_count++;
				end else begin
					exp_w = escaped_q.pop_front();
					if (esc_byte !== exp_w.esc_byte) begin
						$error("esc_byte expected %h actual %h", exp_w.esc_byte, esc_byte);
						fail_count++;
					end
					if (byte_valid !== exp_w.byte_valid) begin
						$error("byte_valid expected %b actual %b",
							exp_w.byte_valid, byte_valid);
						fail_count++;
					end
					if (last !== exp_w.last) begin
						$error("last expected %b actual %b", exp_w.last, last);
						fail_count++;
					end
				end
			end
		end
		pending = escaped_q.size();
	end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the UTF-8 to PDF literal string escaper: stimulus, idling and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_WORDS = 105;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte = '0;
	logic       end_of_text = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] esc_byte;
	logic       byte_valid;
	logic       last;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned cycles = 0;
	int unsigned sent_words = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	// {end_of_text, in_byte}
	logic [8:0] directed_words [24] = '{
		{1'b0, 8'h41}, {1'b0, u8esc_pkg::CH_LPAREN}, {1'b0, u8esc_pkg::CH_RPAREN},
		{1'b0, u8esc_pkg::CH_BSLASH},
		{1'b0, 8'h00}, {1'b0, 8'h7F},
		{1'b0, 8'hC3}, {1'b0, 8'hA9},
		{1'b0, 8'hE2}, {1'b0, 8'h82}, {1'b0, 8'hAC},
		{1'b0, 8'hF0}, {1'b0, 8'h9F}, {1'b0, 8'h98}, {1'b0, 8'h80},
		{1'b0, 8'h80}, {1'b0, 8'hFF},
		{1'b0, 8'hC3}, {1'b0, 8'h41},
		{1'b0, 8'hC0}, {1'b0, 8'h80},
		{1'b1, 8'hE2}, {1'b1, 8'hBF}, {1'b1, 8'h7E}
	};

	always #1 clk = ~clk;

	utf8_to_pdf_literal_escaper u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.esc_byte   (esc_byte),
		.byte_valid (byte_valid),
		.last       (last)
	);

	escaper_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.esc_byte   (esc_byte),
		.byte_valid (byte_valid),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("utf8_to_pdf_literal_escaper verification failed");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] b, input logic eot);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_text <= eot;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_words++;
	endtask

	task automatic drain_output();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// mostly well-formed text, some noise, some cut short
	task automatic send_text();
		logic [7:0]  text_q[$];
		logic [20:0] cp;
		int unsigned n_chars;
		int unsigned pick;
		n_chars = $urandom_range(1, 8);
		repeat (n_chars) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				text_q.push_back(8'($urandom_range(0, 127)));
			end else if (pick < 65) begin
				cp = $urandom_range(1) ? 21'($urandom_range(128, 255))
					: 21'($urandom_range(0, 'h7FF));
				text_q.push_back(u8esc_pkg::LEAD2_TAG | {3'b0, cp[10:6]});
				text_q.push_back(u8esc_pkg::CONT_TAG | {2'b0, cp[5:0]});
			end else if (pick < 78) begin
				cp = 21'($urandom_range(0, 'hFFFF));
				text_q.push_back(u8esc_pkg::LEAD3_TAG | {4'b0, cp[15:12]});
				text_q.push_back(u8esc_pkg::CONT_TAG | {2'b0, cp[11:6]});
				text_q.push_back(u8esc_pkg::CONT_TAG | {2'b0, cp[5:0]});
			end else if (pick < 86) begin
				cp = 21'($urandom_range(0, 'h1FFFFF));
				text_q.push_back(u8esc_pkg::LEAD4_TAG | {5'b0, cp[20:18]});
				text_q.push_back(u8esc_pkg::CONT_TAG | {2'b0, cp[17:12]});
				text_q.push_back(u8esc_pkg::CONT_TAG | {2'b0, cp[11:6]});
				text_q.push_back(u8esc_pkg::CONT_TAG | {2'b0, cp[5:0]});
			end else begin
				text_q.push_back(8'($urandom_range(0, 255)));
			end
		end
		if (text_q.size() > 1 && $urandom_range(9) == 0)
			void'(text_q.pop_back());
		foreach (text_q[i])
			send_word(text_q[i], i == text_q.size() - 1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
				default: begin send_idle_pct = 19; recv_stall_pct = 19; end
			endcase
			if (phase == 0)
				foreach (directed_words[i])
					send_word(directed_words[i][7:0], directed_words[i][8]);
			while (sent_words < (phase + 1) * PHASE_WORDS)
				send_text();
			drain_output();
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("utf8_to_pdf_literal_escaper verification clean");
		else
			$display("utf8_to_pdf_literal_escaper verification failed");
		$finish;
	end

endmodule
